FILE: rtl/drsa_pkg.sv
// Shared types and constants for the DER RSA key parser.
// Holds the transaction structs, configuration struct, register indexes and status codes.
// No dependencies.
`default_nettype none

package drsa_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] out_byte;
    logic [1:0] key_part;
    logic       part_end;
    logic       done_res;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    logic        key_kind;
    logic [13:0] total_length;
    logic [7:0]  sequence_tag;
  } cfg_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_KIND     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQUENCE_TAG = 2'd2;

  localparam logic [7:0] SEQ_TAG_RESET = 8'd16;
  localparam logic [31:0] INTEGER_TAG  = 32'h02;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_HEADER = 3'd1;
  localparam logic [2:0] ST_OVERRUN    = 3'd2;
  localparam logic [2:0] ST_TRAILING   = 3'd3;
  localparam logic [2:0] ST_TRUNCATED  = 3'd4;

  localparam logic [1:0] PART_N       = 2'd0;
  localparam logic [1:0] PART_E       = 2'd1;
  localparam logic [1:0] PART_DISCARD = 2'd3;

  localparam logic [3:0] PUBLIC_COUNT  = 4'd2;
  localparam logic [3:0] PRIVATE_COUNT = 4'd9;

endpackage

`default_nettype wire

FILE: rtl/drsa_core.sv
// Per-byte parse step of the DER RSA key parser: parse state registers and the
// combinational next-state and result logic. Depends on drsa_pkg.
`default_nettype none

module drsa_core import drsa_pkg::*; #(
  parameter int MAX_KEY_BYTES = 8192
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire in_item_t  item,
  input  wire cfg_t      cfg,
  output out_item_t      result
);

  localparam int SAT   = (MAX_KEY_BYTES < 16383) ? MAX_KEY_BYTES : 16383;
  localparam int REM_W = $clog2(SAT + 1);

  typedef enum logic [8:0] {
    PH_SEQ_TAG      = 9'b000000001,
    PH_SEQ_TAG_HI   = 9'b000000010,
    PH_SEQ_LEN      = 9'b000000100,
    PH_SEQ_LEN_LONG = 9'b000001000,
    PH_INT_TAG      = 9'b000010000,
    PH_INT_TAG_HI   = 9'b000100000,
    PH_INT_LEN      = 9'b001000000,
    PH_INT_LEN_LONG = 9'b010000000,
    PH_CONTENT      = 9'b100000000
  } phase_t;

  phase_t           phase, phase_next;
  logic [31:0]      tag_acc, tag_acc_next;
  logic [63:0]      len_acc, len_acc_next;
  logic [6:0]       len_left, len_left_next;
  logic [REM_W-1:0] remaining, remaining_next;
  logic [3:0]       int_idx, int_idx_next;
  logic [REM_W-1:0] content_left, content_left_next;
  logic             finished, finished_next;

  // Values after an optional restart; the byte is then parsed from these.
  phase_t           cur_phase;
  logic [31:0]      cur_tag;
  logic [63:0]      cur_len;
  logic [6:0]       cur_len_left;
  logic [REM_W-1:0] cur_rem;
  logic [3:0]       cur_idx;
  logic [REM_W-1:0] cur_content;
  logic             cur_fin;

  logic [REM_W-1:0] sat_length;
  logic [7:0]       b;
  logic [1:0]       part;
  logic             tag_done, len_done, int_end, decided, seq;
  logic [31:0]      tag_val, tag_want;
  logic [63:0]      len_val;
  logic [6:0]       cnt;
  logic [3:0]       count;

  assign sat_length = (32'(cfg.total_length) > 32'(SAT)) ? REM_W'(SAT)
                                                         : REM_W'(cfg.total_length);
  assign b = item.in_byte;
  assign count = cfg.key_kind ? PRIVATE_COUNT : PUBLIC_COUNT;

  always_comb begin
    if (item.start_req) begin
      cur_phase    = PH_SEQ_TAG;
      cur_tag      = '0;
      cur_len      = '0;
      cur_len_left = '0;
      cur_rem      = sat_length;
      cur_idx      = '0;
      cur_content  = '0;
      cur_fin      = 1'b0;
    end else begin
      cur_phase    = phase;
      cur_tag      = tag_acc;
      cur_len      = len_acc;
      cur_len_left = len_left;
      cur_rem      = remaining;
      cur_idx      = int_idx;
      cur_content  = content_left;
      cur_fin      = finished;
    end
  end

  always_comb begin
    if (!cfg.key_kind) begin
      part = (cur_idx == 4'd0) ? PART_N : PART_E;
    end else if (cur_idx >= 4'd1 && cur_idx <= 4'd3) begin
      part = 2'(cur_idx - 4'd1);
    end else begin
      part = PART_DISCARD;
    end
  end

  always_comb begin
    phase_next        = cur_phase;
    tag_acc_next      = cur_tag;
    len_acc_next      = cur_len;
    len_left_next     = cur_len_left;
    remaining_next    = cur_rem;
    int_idx_next      = cur_idx;
    content_left_next = cur_content;
    finished_next     = cur_fin;
    result            = '0;
    tag_done          = 1'b0;
    len_done          = 1'b0;
    int_end           = 1'b0;
    decided           = 1'b0;
    tag_val           = '0;
    len_val           = '0;
    cnt               = b[6:0];
    seq               = 1'b0;
    tag_want          = INTEGER_TAG;

    if (!cur_fin) begin
      if (cur_rem == '0) begin
        decided       = 1'b1;
        result.status = ST_TRUNCATED;
      end else begin
        remaining_next = cur_rem - REM_W'(1);
        case (cur_phase)
          PH_SEQ_TAG, PH_INT_TAG: begin
            tag_acc_next = '0;
            if (b[4:0] == 5'h1f) begin
              phase_next = (cur_phase == PH_SEQ_TAG) ? PH_SEQ_TAG_HI : PH_INT_TAG_HI;
            end else begin
              tag_done = 1'b1;
              tag_val  = 32'(b[4:0]);
            end
          end
          PH_SEQ_TAG_HI, PH_INT_TAG_HI: begin
            tag_acc_next = {cur_tag[24:0], b[6:0]};
            if (!b[7]) begin
              tag_done = 1'b1;
              tag_val  = tag_acc_next;
            end
          end
          PH_SEQ_LEN, PH_INT_LEN: begin
            len_acc_next = '0;
            if (!b[7]) begin
              len_done = 1'b1;
              len_val  = 64'(b);
            end else if (32'(cnt) > 32'(remaining_next) || cnt == 7'd0) begin
              // A count that cannot fit, or a zero count, means length zero.
              len_done = 1'b1;
              len_val  = '0;
            end else begin
              len_left_next = cnt;
              phase_next = (cur_phase == PH_SEQ_LEN) ? PH_SEQ_LEN_LONG : PH_INT_LEN_LONG;
            end
          end
          PH_SEQ_LEN_LONG, PH_INT_LEN_LONG: begin
            len_acc_next  = {cur_len[55:0], b};
            len_left_next = cur_len_left - 7'd1;
            if (len_left_next == 7'd0) begin
              len_done = 1'b1;
              len_val  = len_acc_next;
            end
          end
          default: begin
            result.key_part = part;
            if (part != PART_DISCARD) begin
              result.data_valid = 1'b1;
              result.out_byte   = b;
            end
            content_left_next = cur_content - REM_W'(1);
            if (content_left_next == '0) begin
              int_end = 1'b1;
            end
          end
        endcase

        if (tag_done) begin
          seq      = (cur_phase == PH_SEQ_TAG) || (cur_phase == PH_SEQ_TAG_HI);
          tag_want = seq ? 32'(cfg.sequence_tag) : INTEGER_TAG;
          if (tag_val != tag_want) begin
            decided       = 1'b1;
            result.status = ST_BAD_HEADER;
          end else begin
            phase_next = seq ? PH_SEQ_LEN : PH_INT_LEN;
          end
        end

        if (len_done) begin
          seq          = (cur_phase == PH_SEQ_LEN) || (cur_phase == PH_SEQ_LEN_LONG);
          len_acc_next = len_val;
          if (seq) begin
            if (len_val == '0) begin
              decided       = 1'b1;
              result.status = ST_BAD_HEADER;
            end else begin
              phase_next = PH_INT_TAG;
            end
          end else if (len_val > 64'(remaining_next)) begin
            decided       = 1'b1;
            result.status = ST_OVERRUN;
          end else if (len_val == '0) begin
            int_end = 1'b1;
          end else begin
            content_left_next = len_val[REM_W-1:0];
            phase_next        = PH_CONTENT;
          end
        end

        if (int_end) begin
          result.part_end = 1'b1;
          result.key_part = part;
          int_idx_next    = cur_idx + 4'd1;
          if (int_idx_next >= count) begin
            decided       = 1'b1;
            result.status = (remaining_next != '0) ? ST_TRAILING : ST_OK;
          end else begin
            phase_next = PH_INT_TAG;
          end
        end

        if (!decided && remaining_next == '0) begin
          decided       = 1'b1;
          result.status = ST_TRUNCATED;
        end
      end

      if (decided) begin
        finished_next   = 1'b1;
        result.done_res = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SEQ_TAG;
      tag_acc      <= '0;
      len_acc      <= '0;
      len_left     <= '0;
      remaining    <= '0;
      int_idx      <= '0;
      content_left <= '0;
      finished     <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      tag_acc      <= tag_acc_next;
      len_acc      <= len_acc_next;
      len_left     <= len_left_next;
      remaining    <= remaining_next;
      int_idx      <= int_idx_next;
      content_left <= content_left_next;
      finished     <= finished_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/drsa_out_buf.sv
// Two-entry result queue that decouples the parse step from the output handshake.
// Depends on drsa_pkg.
`default_nettype none

module drsa_out_buf import drsa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire out_item_t push_data,
  output logic           has_space,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  out_item_t  entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign has_space = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entry[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/der_rsa_key_parser.sv
// Top level of the DER RSA key parser: configuration registers, input register,
// parse step and result queue. Depends on drsa_pkg, drsa_core and drsa_out_buf.
`default_nettype none

// Parses a DER-encoded PKCS#1 RSA key (public: n, e; private: nine integers,
// n, e and d kept) one byte per transaction and returns exactly one result per
// byte: a content byte of a kept integer with its part, the end-of-integer mark,
// and once per parse the outcome. A byte with start_req set restarts the parse
// and loads the byte budget from total_length, saturated to MAX_KEY_BYTES.
// The block sustains one byte per clock cycle while the result queue has room, set by
// the single per-byte state update in drsa_core; a result passes through the input
// register and then the result queue before it is presented, and in_ready stays
// high while the two-entry result queue has room even when a result is waiting.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata; the user
// must write them only while the block is idle, which the block does not enforce;
// index 0 key_kind, 1 total_length, 2 sequence_tag.
module der_rsa_key_parser import drsa_pkg::*; #(
  parameter int MAX_KEY_BYTES = 8192
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      buf_space;
  logic      advance;
  out_item_t step_result;

  assign advance  = s1_valid && buf_space;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_kind     <= 1'b0;
      cfg.total_length <= '0;
      cfg.sequence_tag <= SEQ_TAG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_KIND:     cfg.key_kind     <= cfg_wdata[0];
        CFG_TOTAL_LENGTH: cfg.total_length <= cfg_wdata[13:0];
        CFG_SEQUENCE_TAG: cfg.sequence_tag <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= in_data;
    end
  end

  drsa_core #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (s1_item),
    .cfg    (cfg),
    .result (step_result)
  );

  drsa_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .push_data (step_result),
    .has_space (buf_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/drsa_checker.sv
// Port-level checks for der_rsa_key_parser, attached by the bind at the end.
// Depends on drsa_pkg.
`default_nettype none

module drsa_checker import drsa_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire out_item_t             out_data
);

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result presented right after reset");

  a_kept_part: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.data_valid |-> out_data.key_part != PART_DISCARD)
    else $error("kept byte tagged as discarded integer");

  a_status_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.done_res |-> out_data.status == ST_OK)
    else $error("status set without an outcome");

  a_byte_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.data_valid |-> out_data.out_byte == 8'd0)
    else $error("out_byte nonzero without data_valid");

endmodule

bind der_rsa_key_parser drsa_checker u_drsa_checker (.*);

`default_nettype wire

FILE: sim/der_key_checker.sv
// Checker for the DER RSA key parser: tracks register writes, predicts one result per
// accepted byte and compares every accepted result field by field.
// Depends on drsa_pkg.
module der_key_checker import drsa_pkg::*; #(
  parameter int MAX_KEY_BYTES = 8192
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    SEQ_TAG_FIRST, SEQ_TAG_MORE, SEQ_LEN_FIRST, SEQ_LEN_MORE,
    INT_TAG_FIRST, INT_TAG_MORE, INT_LEN_FIRST, INT_LEN_MORE, INT_BODY
  } parse_step_e;

  localparam logic [4:0] HIGH_TAG_MARK = 5'h1f;

  // Register copies.
  logic        kind_q;
  logic [13:0] budget_cfg;
  logic [7:0]  seq_tag_cfg;

  // Parser state.
  parse_step_e step;
  logic [31:0] tag_acc;
  logic [63:0] len_acc;
  logic [6:0]  len_octets_left;
  logic [13:0] left;
  logic [3:0]  int_idx;
  logic [13:0] body_left;
  logic        settled;

  out_item_t res;
  out_item_t pending_results[$];
  int        err_total = 0;

  function automatic logic [1:0] part_now();
    if (!kind_q) return (int_idx == 4'd0) ? PART_N : PART_E;
    if (int_idx >= 4'd1 && int_idx <= 4'd3) return 2'(int_idx - 4'd1);
    return PART_DISCARD;
  endfunction

  task automatic conclude(input logic [2:0] st);
    settled = 1'b1;
    res.done_res = 1'b1;
    res.status = st;
  endtask

  task automatic close_integer();
    logic [3:0] count;
    count = kind_q ? PRIVATE_COUNT : PUBLIC_COUNT;
    res.part_end = 1'b1;
    res.key_part = part_now();
    int_idx = int_idx + 4'd1;
    if (int_idx >= count) conclude(left != 14'd0 ? ST_TRAILING : ST_OK);
    else step = INT_TAG_FIRST;
  endtask

  task automatic finish_tag(input logic [31:0] tag);
    logic        outer;
    logic [31:0] want;
    outer = (step == SEQ_TAG_FIRST || step == SEQ_TAG_MORE);
    want = outer ? {24'd0, seq_tag_cfg} : INTEGER_TAG;
    if (tag != want) conclude(ST_BAD_HEADER);
    else step = outer ? SEQ_LEN_FIRST : INT_LEN_FIRST;
  endtask

  task automatic finish_length(input logic [63:0] len);
    logic outer;
    outer = (step == SEQ_LEN_FIRST || step == SEQ_LEN_MORE);
    len_acc = len;
    if (outer) begin
      if (len == 64'd0) conclude(ST_BAD_HEADER);
      else step = INT_TAG_FIRST;
    end else if (len > {50'd0, left}) begin
      conclude(ST_OVERRUN);
    end else if (len == 64'd0) begin
      close_integer();
    end else begin
      body_left = len[13:0];
      step = INT_BODY;
    end
  endtask

  task automatic parse_der_byte(input in_item_t it);
    logic [7:0] b;
    b = it.in_byte;
    res = '0;
    if (it.start_req) begin
      step = SEQ_TAG_FIRST;
      tag_acc = '0;
      len_acc = '0;
      len_octets_left = '0;
      int_idx = '0;
      body_left = '0;
      settled = 1'b0;
      left = (budget_cfg > MAX_KEY_BYTES) ? 14'(MAX_KEY_BYTES) : budget_cfg;
    end
    if (!settled) begin
      if (left == 14'd0) begin
        conclude(ST_TRUNCATED);
      end else begin
        left = left - 14'd1;
        case (step)
          SEQ_TAG_FIRST, INT_TAG_FIRST: begin
            tag_acc = '0;
            if (b[4:0] == HIGH_TAG_MARK)
              step = (step == SEQ_TAG_FIRST) ? SEQ_TAG_MORE : INT_TAG_MORE;
            else finish_tag({27'd0, b[4:0]});
          end
          SEQ_TAG_MORE, INT_TAG_MORE: begin
            tag_acc = {tag_acc[24:0], b[6:0]};
            if (!b[7]) finish_tag(tag_acc);
          end
          SEQ_LEN_FIRST, INT_LEN_FIRST: begin
            len_acc = '0;
            if (!b[7]) begin
              finish_length({56'd0, b});
            end else if (b[6:0] > left || b[6:0] == 7'd0) begin
              // A count that cannot fit, or no count at all, means length zero.
              finish_length(64'd0);
            end else begin
              len_octets_left = b[6:0];
              step = (step == SEQ_LEN_FIRST) ? SEQ_LEN_MORE : INT_LEN_MORE;
            end
          end
          SEQ_LEN_MORE, INT_LEN_MORE: begin
            len_acc = {len_acc[55:0], b};
            len_octets_left = len_octets_left - 7'd1;
            if (len_octets_left == 7'd0) finish_length(len_acc);
          end
          default: begin
            res.key_part = part_now();
            if (res.key_part != PART_DISCARD) begin
              res.data_valid = 1'b1;
              res.out_byte = b;
            end
            body_left = body_left - 14'd1;
            if (body_left == 14'd0) close_integer();
          end
        endcase
        if (!settled && left == 14'd0) conclude(ST_TRUNCATED);
      end
    end
  endtask

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      err_total++;
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      kind_q = 1'b0;
      budget_cfg = '0;
      seq_tag_cfg = SEQ_TAG_RESET;
      step = SEQ_TAG_FIRST;
      tag_acc = '0;
      len_acc = '0;
      len_octets_left = '0;
      left = '0;
      int_idx = '0;
      body_left = '0;
      settled = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_KIND:     kind_q = cfg_wdata[0];
          CFG_TOTAL_LENGTH: budget_cfg = cfg_wdata;
          CFG_SEQUENCE_TAG: seq_tag_cfg = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        parse_der_byte(in_data);
        pending_results.push_back(res);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          err_total++;
          $display("%0t: result expected none, got %h", $time, out_data);
        end else begin
          want = pending_results.pop_front();
          check_field("data_valid", 8'(want.data_valid), 8'(out_data.data_valid));
          check_field("out_byte", want.out_byte, out_data.out_byte);
          check_field("key_part", 8'(want.key_part), 8'(out_data.key_part));
          check_field("part_end", 8'(want.part_end), 8'(out_data.part_end));
          check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
          check_field("status", 8'(want.status), 8'(out_data.status));
        end
      end
    end
    outstanding <= pending_results.size();
    mismatches <= err_total;
  end

endmodule

FILE: sim/tb.sv
// Top of the DER RSA key parser testbench: clock, reset, key byte stimulus with random
// gaps and stalls, register writes, watchdog and verdict.
// Depends on drsa_pkg, der_rsa_key_parser and der_key_checker.
module tb import drsa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 1000;
  localparam int BYTE_GOAL = 1900;

  typedef enum int {
    CLEAN, WRONG_SEQ_TAG, WRONG_INT_TAG, ZERO_SEQ_LEN, HUGE_LEN_COUNT, LONG_INT,
    SHORT_BUDGET, LONG_BUDGET, FLIP_BYTE, KIND_SWITCH, TAIL_BYTES, NOISE
  } flaw_e;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int sink_wait = 0;
  int quiet = 0;
  int sent = 0;
  bit calm = 1'b0;

  in_item_t   key_q[$];
  logic [7:0] raw[$];

  der_rsa_key_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  der_key_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: after each transaction, hold ready low for a freshly drawn stall unless calm.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_wait <= 0;
    end else if (out_valid && out_ready) begin
      sink_wait <= calm ? 0 : $urandom_range(0, 13);
      out_ready <= calm;
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      out_ready <= (sink_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic put(input logic [7:0] b);
    key_q.push_back('{in_byte: b, start_req: 1'b0});
  endtask

  task automatic put_tag(input int tag_num);
    int form;
    form = $urandom_range(0, 7);
    if (tag_num < 31 && form != 0) begin
      put({3'($urandom), tag_num[4:0]});
    end else begin
      put({3'($urandom), 5'h1f});
      // A leading zero group in the high-tag form leaves the number unchanged.
      if (form == 1) put(8'h80);
      if (tag_num > 127) put({1'b1, tag_num[13:7]});
      put({1'b0, tag_num[6:0]});
    end
  endtask

  task automatic put_length(input int len);
    int form;
    int cnt;
    form = $urandom_range(0, 7);
    if (len == 0 && form == 6) begin
      put(8'h80);
    end else if (len < 128 && form < 5) begin
      put(len[7:0]);
    end else if (form == 7) begin
      // Overlong count: the leading garbage is shifted out of the 64-bit length.
      cnt = $urandom_range(9, 10);
      put(8'h80 | 8'(cnt));
      repeat (cnt - 8) put(8'($urandom));
      repeat (6) put(8'h00);
      put(len[15:8]);
      put(len[7:0]);
    end else begin
      cnt = ((len > 255) ? 2 : 1) + $urandom_range(0, 1);
      put(8'h80 | 8'(cnt));
      for (int i = cnt - 1; i >= 0; i--) put(8'(len >> (8 * i)));
    end
  endtask

  task automatic build_key(input bit kind, input logic [7:0] tag, input flaw_e flaw);
    in_item_t body[$];
    int n_ints;
    int odd_one;
    int len;
    int r;
    key_q = {};
    n_ints = kind ? 9 : 2;
    odd_one = $urandom_range(0, n_ints - 1);
    for (int k = 0; k < n_ints; k++) begin
      if (flaw == WRONG_INT_TAG && k == odd_one) put_tag(2 ^ (1 << $urandom_range(0, 4)));
      else put_tag(2);
      r = $urandom_range(0, 63);
      len = (r == 0) ? $urandom_range(128, 300) : (r < 8) ? 0 : $urandom_range(1, 8);
      if (flaw == HUGE_LEN_COUNT && k == odd_one) put(8'h80 | 8'($urandom_range(100, 127)));
      else if (flaw == LONG_INT && k == odd_one) put_length(len + $urandom_range(1, 5000));
      else put_length(len);
      repeat (len) put(8'($urandom_range(0, 255)));
    end
    body = key_q;
    key_q = {};
    if (flaw == WRONG_SEQ_TAG) put_tag(int'(tag) ^ (1 << $urandom_range(0, 7)));
    else put_tag(int'(tag));
    if (flaw == ZERO_SEQ_LEN) put($urandom_range(0, 1) ? 8'h00 : 8'h80);
    else put_length(body.size());
    key_q = {key_q, body};
    key_q[0].start_req = 1'b1;
  endtask

  task automatic load_bytes(input bit restart);
    key_q = {};
    foreach (raw[i]) put(raw[i]);
    key_q[0].start_req = restart;
  endtask

  task automatic offer(input in_item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Registers are rewritten only once the block has returned every result.
  task automatic run_key(input bit kind, input logic [13:0] total, input logic [7:0] tag,
                         input int switch_at);
    drain();
    write_cfg(CFG_KEY_KIND, {13'd0, kind});
    write_cfg(CFG_TOTAL_LENGTH, total);
    write_cfg(CFG_SEQUENCE_TAG, {6'd0, tag});
    foreach (key_q[i]) begin
      if (i == switch_at) begin
        drain();
        write_cfg(CFG_KEY_KIND, {13'd0, !kind});
      end
      offer(key_q[i]);
    end
    sent += key_q.size();
  endtask

  initial begin
    int r;
    int total;
    int idx;
    int switch_at;
    bit kind;
    logic [7:0] tag;
    flaw_e flaw;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Bytes before any start, then a start with an empty budget.
    raw = '{8'h00, 8'hff};
    load_bytes(1'b0);
    run_key(1'b0, 14'd0, SEQ_TAG_RESET, -1);
    raw = '{8'h30};
    load_bytes(1'b1);
    run_key(1'b0, 14'd0, SEQ_TAG_RESET, -1);
    // Public key with one-byte integers and extreme content bytes.
    raw = '{8'h30, 8'h06, 8'h02, 8'h01, 8'hff, 8'h02, 8'h01, 8'h00};
    load_bytes(1'b1);
    run_key(1'b0, 14'd8, SEQ_TAG_RESET, -1);
    // High-form outer tag 255 and empty integers, one with a zero-count long length.
    raw = '{8'hff, 8'h81, 8'h7f, 8'h01, 8'h02, 8'h80, 8'h02, 8'h00};
    load_bytes(1'b1);
    run_key(1'b0, 14'd8, 8'hff, -1);
    // Zero outer length under a budget that saturates.
    raw = '{8'h30, 8'h00};
    load_bytes(1'b1);
    run_key(1'b1, 14'h3fff, SEQ_TAG_RESET, -1);

    while (sent < BYTE_GOAL) begin
      r = $urandom_range(0, 23);
      flaw = (r <= 11 || r == 23) ? CLEAN : flaw_e'(r - 11);
      kind = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 7);
      if (r == 0) tag = 8'($urandom_range(0, 255));
      else if (r == 1) tag = $urandom_range(0, 1) ? 8'hff : 8'h00;
      else tag = SEQ_TAG_RESET;
      if (flaw == NOISE) begin
        key_q = {};
        repeat ($urandom_range(1, 20)) put(8'($urandom));
        foreach (key_q[i]) key_q[i].start_req = (i == 0) || ($urandom_range(0, 15) == 0);
        total = $urandom_range(0, 30);
      end else begin
        build_key(kind, tag, flaw);
        total = key_q.size();
        case (flaw)
          SHORT_BUDGET: total = $urandom_range(1, key_q.size() - 1);
          LONG_BUDGET: begin
            if ($urandom_range(0, 3) == 0) total = $urandom_range(0, 1) ? 8192 : 16383;
            else total = key_q.size() + $urandom_range(1, 20);
          end
          FLIP_BYTE: begin
            idx = $urandom_range(0, key_q.size() - 1);
            key_q[idx].in_byte = key_q[idx].in_byte ^ 8'(1 << $urandom_range(0, 7));
          end
          TAIL_BYTES: repeat ($urandom_range(1, 4)) put(8'($urandom));
          default: ;
        endcase
      end
      switch_at = (flaw == KIND_SWITCH) ? $urandom_range(1, key_q.size() - 1) : -1;
      calm = ($urandom_range(0, 4) == 0);
      run_key(kind, total[13:0], tag, switch_at);
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/drsa_pkg.sv
rtl/drsa_core.sv
rtl/drsa_out_buf.sv
rtl/der_rsa_key_parser.sv
rtl/drsa_checker.sv
sim/der_key_checker.sv
sim/tb.sv
